// File: rtl/lz11d_pkg.sv
// ----------------------------------------------------------------------------
// lz11d_pkg
// Types and constants shared by the LZ11-style stream decoder.
// ----------------------------------------------------------------------------
package lz11d_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_PULL = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic [2:0] ST_DATA       = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_BAD_REF    = 3'd2;
  localparam logic [2:0] ST_TRUNC      = 3'd3;
  localparam logic [2:0] ST_COMPLETE   = 3'd4;
  localparam logic [2:0] ST_ORDER      = 3'd5;

  localparam logic [7:0]  MAGIC          = 8'h19;
  localparam logic [3:0]  MODE_SHORT     = 4'd0;
  localparam logic [3:0]  MODE_LONG      = 4'd1;
  localparam logic [2:0]  NEED_SHORT     = 3'd3;
  localparam logic [2:0]  NEED_LONG      = 3'd4;
  localparam logic [2:0]  NEED_PLAIN     = 3'd2;
  localparam logic [16:0] LEN_BIAS_SHORT = 17'h00011;
  localparam logic [16:0] LEN_BIAS_LONG  = 17'h00111;
  localparam logic [23:0] SIZE_LIMIT_RST = 24'hFFFFFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } res_t;

endpackage

// File: rtl/lz11d_in_if.sv
// ----------------------------------------------------------------------------
// lz11d_in_if
// Input channel: command and compressed byte with valid/ready.
// ----------------------------------------------------------------------------
interface lz11d_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// File: rtl/lz11d_out_if.sv
// ----------------------------------------------------------------------------
// lz11d_out_if
// Result channel: decompressed byte, status and last with valid/ready.
// ----------------------------------------------------------------------------
interface lz11d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// File: rtl/lz11d_out_fifo.sv
// ----------------------------------------------------------------------------
// lz11d_out_fifo
// Small result queue that decouples the decoder pipeline from the sink.
// ----------------------------------------------------------------------------
module lz11d_out_fifo
  import lz11d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  res_t               push_data,
  output logic [FIFO_CW-1:0] level,
  lz11d_out_if.source        out_ch
);

  res_t               store [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic               pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (count_r != '0);
  assign out_ch.out_byte = store[rd_ptr_r].out_byte;
  assign out_ch.status   = store[rd_ptr_r].status;
  assign out_ch.last     = store[rd_ptr_r].last;
  assign level        = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + FIFO_CW'(1);
        2'b01:   count_r <= count_r - FIFO_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/lz11_style_stream_decoder.sv
// ----------------------------------------------------------------------------
// lz11_style_stream_decoder
// LZ11-style decompressor: header check, flag/token parse, 4 KiB history.
// Each result is registered in stage s1 and queued in the output FIFO.
// Throughput: one item per cycle while the result queue has room; the
// history RAM takes one read at accept and one write in the cycle after,
// with forwarding for back-to-back copies.
// Reset clears all stream state and sets size_limit to 0xFFFFFF; the
// history RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module lz11_style_stream_decoder
  import lz11d_pkg::*;
#(
  parameter int WINDOW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  lz11d_in_if.sink    in_ch,
  lz11d_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  localparam int WIN_AW = $clog2(WINDOW_BYTES);

  logic [7:0] hist_mem [WINDOW_BYTES];

  phase_t      phase_r, phase_nxt;
  logic [23:0] size_limit_r;
  logic [23:0] written_r, written_nxt;
  logic [23:0] expected_r, expected_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  flag_bits_r, flag_bits_nxt;
  logic [3:0]  flags_left_r, flags_left_nxt;
  logic [7:0]  tok0_r, tok0_nxt;
  logic [7:0]  tok1_r, tok1_nxt;
  logic [7:0]  tok2_r, tok2_nxt;
  logic [1:0]  tok_phase_r, tok_phase_nxt;
  logic [16:0] copy_rem_r, copy_rem_nxt;
  logic [12:0] copy_dist_r, copy_dist_nxt;

  logic              s1_res_r, s1_we_r, s1_copy_r, fwd_hit_r, s1_last_r;
  logic [2:0]        s1_status_r;
  logic [7:0]        s1_byte_r, fwd_data_r, rd_data_r, s1_wbyte;
  logic [WIN_AW-1:0] s1_waddr_r;

  logic              in_acc;
  logic [FIFO_CW-1:0] fifo_level;
  logic [7:0]        b;
  logic [23:0]       written_inc;
  logic              reach_end;
  logic [23:0]       hdr_full;
  logic              hdr_bad;
  logic [3:0]        mode;
  logic [2:0]        need;
  logic [2:0]        tok_cnt;
  logic              tok_done;
  logic [16:0]       tok_len;
  logic [11:0]       dist_field;
  logic [12:0]       tok_dist;
  logic              ref_bad;
  logic [WIN_AW-1:0] rd_addr;
  logic              res_v, res_last, wr_en, copy_en;
  logic [2:0]        res_status;
  logic [7:0]        res_byte;
  res_t              push_data;

  assign b           = in_ch.data_byte;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = ({1'b0, fifo_level} + {{FIFO_CW{1'b0}}, s1_res_r})
                       < (FIFO_CW + 1)'(FIFO_DEPTH);
  assign written_inc = written_r + 24'd1;
  assign reach_end   = (written_inc == expected_r);
  assign hdr_full    = {b, expected_r[15:0]};
  assign hdr_bad     = (hdr_full == 24'd0) || (hdr_full > size_limit_r);
  assign mode        = (tok_phase_r == 2'd0) ? b[7:4] : tok0_r[7:4];
  assign need        = (mode == MODE_SHORT) ? NEED_SHORT :
                       (mode == MODE_LONG)  ? NEED_LONG  : NEED_PLAIN;
  assign tok_cnt     = {1'b0, tok_phase_r} + 3'd1;
  assign tok_done    = (tok_cnt == need);
  assign rd_addr     = written_r[WIN_AW-1:0] - copy_dist_r[WIN_AW-1:0];

  always_comb begin
    case (mode)
      MODE_SHORT: begin
        tok_len    = {9'd0, tok0_r[3:0], tok1_r[7:4]} + LEN_BIAS_SHORT;
        dist_field = {tok1_r[3:0], b};
      end
      MODE_LONG: begin
        tok_len    = {1'b0, tok0_r[3:0], tok1_r, tok2_r[7:4]} + LEN_BIAS_LONG;
        dist_field = {tok2_r[3:0], b};
      end
      default: begin
        tok_len    = {13'd0, mode} + 17'd1;
        dist_field = {tok0_r[3:0], b};
      end
    endcase
  end

  assign tok_dist = {1'b0, dist_field} + 13'd1;
  assign ref_bad  = ({11'd0, tok_dist} > written_r) ||
                    ({7'd0, tok_len} > (expected_r - written_r));

  // next state
  always_comb begin
    logic rearm;
    rearm          = 1'b0;
    phase_nxt      = phase_r;
    written_nxt    = written_r;
    expected_nxt   = expected_r;
    hdr_idx_nxt    = hdr_idx_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    tok0_nxt       = tok0_r;
    tok1_nxt       = tok1_r;
    tok2_nxt       = tok2_r;
    tok_phase_nxt  = tok_phase_r;
    copy_rem_nxt   = copy_rem_r;
    copy_dist_nxt  = copy_dist_r;
    if (in_acc) begin
      case (in_ch.cmd)
        CMD_BYTE: begin
          if (phase_r == PH_HEADER) begin
            case (hdr_idx_r)
              2'd0: begin
                if (b != MAGIC) begin
                  phase_nxt = PH_HALT;
                end else begin
                  expected_nxt = 24'd0;
                  hdr_idx_nxt  = 2'd1;
                end
              end
              2'd1: begin
                expected_nxt = {expected_r[23:8], b};
                hdr_idx_nxt  = 2'd2;
              end
              2'd2: begin
                expected_nxt = {expected_r[23:16], b, expected_r[7:0]};
                hdr_idx_nxt  = 2'd3;
              end
              default: begin
                expected_nxt = hdr_full;
                hdr_idx_nxt  = 2'd0;
                if (hdr_bad) begin
                  phase_nxt = PH_HALT;
                end else begin
                  phase_nxt      = PH_BODY;
                  written_nxt    = 24'd0;
                  flags_left_nxt = 4'd0;
                  tok_phase_nxt  = 2'd0;
                  copy_rem_nxt   = 17'd0;
                end
              end
            endcase
          end else if (phase_r == PH_BODY && copy_rem_r == 17'd0) begin
            if (flags_left_r == 4'd0) begin
              flag_bits_nxt  = b;
              flags_left_nxt = 4'd8;
            end else if (!flag_bits_r[7]) begin
              written_nxt    = written_inc;
              flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
              flags_left_nxt = flags_left_r - 4'd1;
              if (reach_end) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              case (tok_phase_r)
                2'd0:    tok0_nxt = b;
                2'd1:    tok1_nxt = b;
                2'd2:    tok2_nxt = b;
                default: tok0_nxt = tok0_r;
              endcase
              if (!tok_done) begin
                tok_phase_nxt = tok_cnt[1:0];
              end else begin
                tok_phase_nxt  = 2'd0;
                flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
                flags_left_nxt = flags_left_r - 4'd1;
                if (ref_bad) begin
                  phase_nxt = PH_HALT;
                end else begin
                  copy_rem_nxt  = tok_len;
                  copy_dist_nxt = tok_dist;
                end
              end
            end
          end
        end
        CMD_PULL: begin
          if (phase_r == PH_BODY && copy_rem_r != 17'd0) begin
            written_nxt  = written_inc;
            copy_rem_nxt = copy_rem_r - 17'd1;
            if (reach_end) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        CMD_END: begin
          rearm = !(phase_r == PH_BODY && copy_rem_r != 17'd0);
        end
        default: rearm = 1'b0;
      endcase
    end
    if (rearm) begin
      phase_nxt      = PH_HEADER;
      written_nxt    = 24'd0;
      expected_nxt   = 24'd0;
      hdr_idx_nxt    = 2'd0;
      flag_bits_nxt  = 8'd0;
      flags_left_nxt = 4'd0;
      tok0_nxt       = 8'd0;
      tok1_nxt       = 8'd0;
      tok2_nxt       = 8'd0;
      tok_phase_nxt  = 2'd0;
      copy_rem_nxt   = 17'd0;
      copy_dist_nxt  = 13'd0;
    end
  end

  // results and window access
  always_comb begin
    res_v      = 1'b0;
    res_status = ST_DATA;
    res_last   = 1'b0;
    res_byte   = 8'd0;
    wr_en      = 1'b0;
    copy_en    = 1'b0;
    case (in_ch.cmd)
      CMD_BYTE: begin
        if (phase_r == PH_HEADER) begin
          if ((hdr_idx_r == 2'd0 && b != MAGIC) || (hdr_idx_r == 2'd3 && hdr_bad)) begin
            res_v      = 1'b1;
            res_status = ST_BAD_HEADER;
            res_last   = 1'b1;
          end
        end else if (phase_r == PH_BODY) begin
          if (copy_rem_r != 17'd0) begin
            res_v      = 1'b1;
            res_status = ST_ORDER;
          end else if (flags_left_r != 4'd0 && !flag_bits_r[7]) begin
            res_v    = 1'b1;
            res_byte = b;
            res_last = reach_end;
            wr_en    = 1'b1;
          end else if (flags_left_r != 4'd0 && tok_done && ref_bad) begin
            res_v      = 1'b1;
            res_status = ST_BAD_REF;
            res_last   = 1'b1;
          end
        end
      end
      CMD_PULL: begin
        res_v = 1'b1;
        if (phase_r == PH_BODY && copy_rem_r != 17'd0) begin
          res_last = reach_end;
          wr_en    = 1'b1;
          copy_en  = 1'b1;
        end else begin
          res_status = ST_ORDER;
        end
      end
      CMD_END: begin
        case (phase_r)
          PH_HEADER: begin
            res_v      = 1'b1;
            res_status = ST_BAD_HEADER;
            res_last   = 1'b1;
          end
          PH_BODY: begin
            res_v      = 1'b1;
            res_status = (copy_rem_r != 17'd0) ? ST_ORDER : ST_TRUNC;
            res_last   = (copy_rem_r == 17'd0);
          end
          PH_DONE: begin
            res_v      = 1'b1;
            res_status = ST_COMPLETE;
            res_last   = 1'b1;
          end
          default: res_v = 1'b0;
        endcase
      end
      default: res_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      size_limit_r <= SIZE_LIMIT_RST;
      written_r    <= '0;
      expected_r   <= '0;
      hdr_idx_r    <= '0;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      tok0_r       <= '0;
      tok1_r       <= '0;
      tok2_r       <= '0;
      tok_phase_r  <= '0;
      copy_rem_r   <= '0;
      copy_dist_r  <= '0;
      s1_res_r     <= 1'b0;
      s1_we_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      written_r    <= written_nxt;
      expected_r   <= expected_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      tok0_r       <= tok0_nxt;
      tok1_r       <= tok1_nxt;
      tok2_r       <= tok2_nxt;
      tok_phase_r  <= tok_phase_nxt;
      copy_rem_r   <= copy_rem_nxt;
      copy_dist_r  <= copy_dist_nxt;
      s1_res_r     <= in_acc && res_v;
      s1_we_r      <= in_acc && wr_en;
      if (cfg_we) begin
        size_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= res_status;
    s1_last_r   <= res_last;
    s1_byte_r   <= res_byte;
    s1_copy_r   <= copy_en;
    s1_waddr_r  <= written_r[WIN_AW-1:0];
    fwd_hit_r   <= s1_we_r && (s1_waddr_r == rd_addr);
    fwd_data_r  <= s1_wbyte;
  end

  assign s1_wbyte = s1_copy_r ? (fwd_hit_r ? fwd_data_r : rd_data_r) : s1_byte_r;

  always_ff @(posedge clk) begin
    if (s1_we_r) begin
      hist_mem[s1_waddr_r] <= s1_wbyte;
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  assign push_data = '{out_byte: s1_wbyte, status: s1_status_r, last: s1_last_r};

  lz11d_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_res_r),
    .push_data (push_data),
    .level     (fifo_level),
    .out_ch    (out_ch)
  );

  a_data_writes_window: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_res_r && s1_status_r == ST_DATA) |-> s1_we_r)
    else $error("data result without window write");

  a_copy_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (copy_rem_r != 17'd0) |-> (phase_r == PH_BODY))
    else $error("copy pending outside body");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (written_r == expected_r))
    else $error("done with byte count mismatch");

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fifo_level} + {{FIFO_CW{1'b0}}, s1_res_r}) <= (FIFO_CW + 1)'(FIFO_DEPTH))
    else $error("result queue overrun");

endmodule
